/* rtl/core/ppc_pkg.sv */
// shared types and constants for the polygon plane clipper
`default_nettype none
package ppc_pkg;
    localparam int COORD_W = 16;
    localparam int PV_W = 36;
    localparam int PLANE_REGS = 6;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_PLANE_COUNT = 3'd0;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
    } vert_t;

    // item queued from the front part to the back part
    typedef struct packed {
        vert_t vert;
        logic  last;
    } fq_item_t;

    typedef enum logic [3:0] {
        B_LOAD, B_START, B_PV_LAST, B_PV, B_DECIDE, B_DIV_GO, B_DIV, B_CROSS_WR,
        B_KEEP_WR, B_COPY, B_EMIT, B_ERR
    } bstate_t;
endpackage
`default_nettype wire

/* rtl/core/ppc_front.sv */
// input stage and short queue ahead of the clipping engine
`default_nettype none
module ppc_front (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire ppc_pkg::fq_item_t in_item,
    output logic                  q_valid,
    input  wire logic             q_ready,
    output ppc_pkg::fq_item_t     q_item
);
    import ppc_pkg::*;
    fq_item_t  mem_reg [4];
    logic [1:0] wp_reg, rp_reg;
    logic [2:0] cnt_reg;
    logic push, pop;

    assign in_ready = (cnt_reg != 3'd4);
    assign q_valid  = (cnt_reg != 3'd0);
    assign q_item   = mem_reg[rp_reg];
    assign push = in_valid && in_ready;
    assign pop  = q_valid && q_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wp_reg] <= in_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push) wp_reg <= wp_reg + 2'd1;
            if (pop) rp_reg <= rp_reg + 2'd1;
            cnt_reg <= cnt_reg + {2'b0, push} - {2'b0, pop};
        end
    end

    a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n) cnt_reg <= 3'd4)
        else $error("queue count out of range");
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 3'd4) |-> !push) else $error("push into full queue");
    a_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (cnt_reg != 3'd0)) else $error("pop from empty queue");
endmodule
`default_nettype wire

/* rtl/core/ppc_div.sv */
// sequential restoring divider, rounded magnitude quotient
`default_nettype none
module ppc_div #(
    parameter int NW = 54,
    parameter int DW = 38
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic [NW-1:0] num,
    input  wire logic [DW-1:0] den,
    output logic               busy,
    output logic [NW-1:0]      quot
);
    localparam int CW = $clog2(NW + 1);
    logic [NW-1:0] q_reg;
    logic [DW:0]   r_reg;
    logic [DW-1:0] d_reg;
    logic [CW-1:0] cnt_reg;
    logic [DW:0]   trial;

    assign busy = (cnt_reg != '0);
    assign quot = q_reg;
    assign trial = {r_reg[DW-1:0], q_reg[NW-1]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (start)
        begin
            cnt_reg <= CW'(NW);
        end
        else if (busy)
        begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    // num already carries den/2 so the quotient comes out rounded
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg <= num;
            r_reg <= '0;
            d_reg <= den;
        end
        else if (busy)
        begin
            if (trial >= {1'b0, d_reg})
            begin
                r_reg <= trial - {1'b0, d_reg};
                q_reg <= {q_reg[NW-2:0], 1'b1};
            end
            else
            begin
                r_reg <= trial;
                q_reg <= {q_reg[NW-2:0], 1'b0};
            end
        end
    end
endmodule
`default_nettype wire

/* rtl/core/ppc_back.sv */
// clipping engine: buffers one polygon and walks it once per plane
`default_nettype none
module ppc_back #(
    parameter int MAX_VERTS = 64,
    parameter int MAX_PLANES = 6
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              q_valid,
    output logic                   q_ready,
    input  wire ppc_pkg::fq_item_t q_item,
    input  wire logic [2:0]        plane_count,
    input  wire logic [63:0]       planes [ppc_pkg::PLANE_REGS],
    output logic                   o_valid,
    input  wire logic              o_ready,
    output ppc_pkg::vert_t         o_vert,
    output logic                   o_last,
    output logic                   o_ovf
);
    import ppc_pkg::*;
    localparam int AW = (MAX_VERTS > 1) ? $clog2(MAX_VERTS) : 1;
    localparam int CW = $clog2(MAX_VERTS + 2);
    localparam int NPL = (MAX_PLANES < PLANE_REGS) ? MAX_PLANES : PLANE_REGS;
    localparam int NUM_W = 54;
    localparam int DEN_W = 38;

    bstate_t state_reg, state_next;
    vert_t src_mem [MAX_VERTS];
    vert_t tgt_mem [MAX_VERTS];
    vert_t src_rd_reg, tgt_rd_reg;

    logic [CW-1:0] n_reg, n_next, m_reg, m_next, j_reg, j_next;
    logic [2:0]    pl_reg, pl_next, npl_reg, npl_next;
    vert_t q_reg, q_next, p_reg, p_next;
    logic signed [PV_W-1:0] tq_reg, tq_next, tp_reg, tp_next;
    logic [1:0]    k_reg, k_next;
    logic signed [COORD_W-1:0] cr_reg [3];
    logic signed [COORD_W-1:0] cr_next [3];
    logic [PV_W:0] acc_reg, acc_next;
    logic          o_valid_reg;

    logic [AW-1:0] src_ra, tgt_ra, src_wa, tgt_wa;
    logic          src_we, tgt_we;
    vert_t         src_wd, tgt_wd;

    logic [63:0] pl_word;
    logic signed [COORD_W-1:0] ca, cb, cc, cd;
    vert_t pv_vert;
    logic signed [PV_W-1:0] pv_term;
    logic signed [COORD_W-1:0] coord_p, coord_q;
    logic signed [PV_W:0] den_s;
    logic [DEN_W-1:0] den_mag;
    logic signed [COORD_W:0] diff;
    logic signed [PV_W+COORD_W+1:0] prod;
    logic neg_num;
    logic [NUM_W-1:0] num_mag;
    logic div_start, div_busy;
    logic [NUM_W-1:0] div_q;
    logic [1:0] term_sel, term_sel_reg;

    assign pl_word = planes[pl_reg];
    assign ca = pl_word[15:0];
    assign cb = pl_word[31:16];
    assign cc = pl_word[47:32];
    assign cd = pl_word[63:48];

    always_ff @(posedge clk)
    begin
        if (src_we) src_mem[src_wa] <= src_wd;
        if (tgt_we) tgt_mem[tgt_wa] <= tgt_wd;
        src_rd_reg <= src_mem[src_ra];
        // target write data passes through when the same target entry is read
        tgt_rd_reg <= (tgt_we && tgt_wa == tgt_ra) ? tgt_wd : tgt_mem[tgt_ra];
    end

    // term 0 works on the vertex still in the read register
    assign pv_vert = (k_reg == 2'd0) ? src_rd_reg : p_reg;

    // one plane term per cycle (a coefficient product or d scaled by 256) into the plane-value accumulator
    always_comb
    begin
        unique case (term_sel_reg)
            2'd0: pv_term = PV_W'(ca * pv_vert.x);
            2'd1: pv_term = PV_W'(cb * pv_vert.y);
            2'd2: pv_term = PV_W'(cc * pv_vert.z);
            default: pv_term = PV_W'({{(PV_W-COORD_W){cd[COORD_W-1]}}, cd} <<< 8);
        endcase
    end

    always_comb
    begin
        unique case (k_reg)
            2'd0: begin coord_p = p_reg.x; coord_q = q_reg.x; end
            2'd1: begin coord_p = p_reg.y; coord_q = q_reg.y; end
            default: begin coord_p = p_reg.z; coord_q = q_reg.z; end
        endcase
    end

    assign den_s = {tp_reg[PV_W-1], tp_reg} - {tq_reg[PV_W-1], tq_reg};
    assign den_mag = den_s[PV_W] ? DEN_W'(-den_s) : DEN_W'(den_s);
    assign diff = {coord_p[COORD_W-1], coord_p} - {coord_q[COORD_W-1], coord_q};
    // num = sign(den) * -tq * diff
    assign prod = (PV_W+COORD_W+2)'(-tq_reg) * diff;
    assign neg_num = (prod < 0) ^ den_s[PV_W];
    assign num_mag = NUM_W'(prod < 0 ? -prod : prod) + NUM_W'(den_mag >> 1);

    ppc_div #(.NW(NUM_W), .DW(DEN_W)) u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start),
        .num(num_mag), .den(den_mag), .busy(div_busy), .quot(div_q)
    );

    always_comb
    begin
        state_next = state_reg;
        n_next = n_reg; m_next = m_reg; j_next = j_reg;
        pl_next = pl_reg; npl_next = npl_reg;
        q_next = q_reg; p_next = p_reg; tq_next = tq_reg; tp_next = tp_reg;
        k_next = k_reg; acc_next = acc_reg;
        cr_next = cr_reg;
        term_sel = term_sel_reg;
        q_ready = 1'b0;
        src_we = 1'b0; tgt_we = 1'b0;
        src_wa = j_reg[AW-1:0]; tgt_wa = m_reg[AW-1:0];
        src_wd = q_item.vert; tgt_wd = p_reg;
        src_ra = j_reg[AW-1:0]; tgt_ra = j_reg[AW-1:0];
        div_start = 1'b0;
        unique case (state_reg)
            B_LOAD:
            begin
                q_ready = !o_valid_reg;
                if (q_valid && q_ready)
                begin
                    if (n_reg < CW'(MAX_VERTS))
                    begin
                        src_we = 1'b1;
                        src_wa = n_reg[AW-1:0];
                        n_next = n_reg + 1'b1;
                    end
                    else
                    begin
                        n_next = CW'(MAX_VERTS + 1);
                    end
                    if (q_item.last)
                    begin
                        npl_next = (plane_count > 3'(NPL)) ? 3'(NPL) : plane_count;
                        pl_next = '0;
                        j_next = '0;
                        if (n_next > CW'(MAX_VERTS)) state_next = B_ERR;
                        else state_next = B_START;
                    end
                end
            end
            B_START:
            begin
                if (pl_reg == npl_reg)
                begin
                    j_next = '0;
                    src_ra = '0;
                    state_next = B_EMIT;
                end
                else
                begin
                    src_ra = AW'(n_reg - 1'b1);
                    m_next = '0; j_next = '0;
                    term_sel = 2'd0; acc_next = '0;
                    state_next = B_PV_LAST;
                end
            end
            B_PV_LAST, B_PV:
            begin
                // term 0 latches the vertex just read and restarts the sum
                if (k_reg == 2'd0)
                begin
                    p_next = src_rd_reg;
                    acc_next = {pv_term[PV_W-1], pv_term};
                end
                else acc_next = acc_reg + {pv_term[PV_W-1], pv_term};
                term_sel = term_sel_reg + 1'b1;
                k_next = k_reg + 1'b1;
                if (k_reg == 2'd3)
                begin
                    k_next = '0;
                    term_sel = '0;
                    if (state_reg == B_PV_LAST)
                    begin
                        tq_next = PV_W'(acc_next);
                        q_next = p_reg;
                        src_ra = j_reg[AW-1:0];
                        state_next = B_PV;
                    end
                    else
                    begin
                        tp_next = PV_W'(acc_next);
                        state_next = B_DECIDE;
                    end
                end
            end
            B_DECIDE:
            begin
                if ((tp_reg >= 0) != (tq_reg >= 0))
                begin
                    if (m_reg >= CW'(MAX_VERTS)) state_next = B_ERR;
                    else
                    begin
                        k_next = '0;
                        state_next = B_DIV_GO;
                    end
                end
                else state_next = B_KEEP_WR;
            end
            B_DIV_GO:
            begin
                // numerator of coordinate k_reg goes into the divider
                div_start = 1'b1;
                state_next = B_DIV;
            end
            B_DIV:
            begin
                if (!div_busy)
                begin
                    cr_next[k_reg] = coord_q + (neg_num ? -COORD_W'(div_q) : COORD_W'(div_q));
                    if (k_reg == 2'd2)
                    begin
                        k_next = '0;
                        state_next = B_CROSS_WR;
                    end
                    else
                    begin
                        k_next = k_reg + 1'b1;
                        state_next = B_DIV_GO;
                    end
                end
            end
            B_CROSS_WR:
            begin
                tgt_we = 1'b1;
                tgt_wd.x = cr_reg[0]; tgt_wd.y = cr_reg[1]; tgt_wd.z = cr_reg[2];
                m_next = m_reg + 1'b1;
                state_next = B_KEEP_WR;
            end
            B_KEEP_WR:
            begin
                if (tp_reg >= 0 && m_reg >= CW'(MAX_VERTS)) state_next = B_ERR;
                else
                begin
                    if (tp_reg >= 0)
                    begin
                        tgt_we = 1'b1;
                        m_next = m_reg + 1'b1;
                    end
                    q_next = p_reg; tq_next = tp_reg;
                    j_next = j_reg + 1'b1;
                    src_ra = AW'(j_next);
                    if (j_next == n_reg)
                    begin
                        if (m_next == '0)
                        begin
                            n_next = '0;
                            state_next = B_LOAD;
                        end
                        else
                        begin
                            j_next = '0;
                            tgt_ra = '0;
                            state_next = B_COPY;
                        end
                    end
                    else state_next = B_PV;
                end
            end
            B_COPY:
            begin
                // reads are registered; j_reg is the entry being copied, read in the cycle before
                tgt_ra = AW'(j_reg + 1'b1);
                src_we = 1'b1;
                src_wa = j_reg[AW-1:0];
                src_wd = tgt_rd_reg;
                j_next = j_reg + 1'b1;
                if (j_next == m_reg)
                begin
                    n_next = m_reg;
                    pl_next = pl_reg + 1'b1;
                    state_next = B_START;
                end
            end
            B_EMIT:
            begin
                if (!o_valid_reg)
                begin
                    j_next = j_reg + 1'b1;
                    src_ra = AW'(j_next);
                    if (j_next == n_reg)
                    begin
                        n_next = '0;
                        state_next = B_LOAD;
                    end
                end
                else src_ra = j_reg[AW-1:0];
            end
            B_ERR:
            begin
                if (!o_valid_reg)
                begin
                    n_next = '0;
                    state_next = B_LOAD;
                end
            end
            default: state_next = B_LOAD;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_LOAD;
            n_reg <= '0; m_reg <= '0; j_reg <= '0;
            pl_reg <= '0; npl_reg <= '0; k_reg <= '0;
            term_sel_reg <= '0; acc_reg <= '0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            n_reg <= n_next; m_reg <= m_next; j_reg <= j_next;
            pl_reg <= pl_next; npl_reg <= npl_next; k_reg <= k_next;
            term_sel_reg <= term_sel; acc_reg <= acc_next;
            if (o_valid_reg && o_ready) o_valid_reg <= 1'b0;
            else if ((state_reg == B_ERR || state_reg == B_EMIT) && !o_valid_reg)
                o_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next; p_reg <= p_next; tq_reg <= tq_next; tp_reg <= tp_next;
        cr_reg <= cr_next;
        if (!o_valid_reg)
        begin
            if (state_reg == B_ERR)
            begin
                o_vert <= '0; o_last <= 1'b1; o_ovf <= 1'b1;
            end
            else
            begin
                o_vert <= src_rd_reg;
                o_last <= (j_reg + 1'b1 == n_reg);
                o_ovf <= 1'b0;
            end
        end
    end

    assign o_valid = o_valid_reg;

    a_load_only: assert property (@(posedge clk) disable iff (!rst_n)
        q_ready |-> state_reg == B_LOAD) else $error("accept outside load");
    a_n_range: assert property (@(posedge clk) disable iff (!rst_n)
        n_reg <= CW'(MAX_VERTS + 1)) else $error("vertex count out of range");
    a_m_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_reg <= CW'(MAX_VERTS)) else $error("target count out of range");
    a_pl_range: assert property (@(posedge clk) disable iff (!rst_n)
        pl_reg <= npl_reg || state_reg == B_LOAD) else $error("plane index beyond count");
endmodule
`default_nettype wire

/* rtl/core/polygon_plane_clipper.sv */
// top level of the polygon plane clipper
`default_nettype none
// Clips a polygon against up to six planes a*x+b*y+c*z+d >= 0 (Sutherland-Hodgman,
// Q8.8). Vertices enter one per cycle, while the queue has room, through a
// four-entry queue into a vertex buffer; after the final vertex the engine
// walks the buffer once per plane, with three 54-step divisions for each
// crossing edge, then copies the survivors back one vertex per cycle and emits
// them, offering the next vertex only once the last has been taken. A polygon
// of more than MAX_VERTS vertices, or one that grows past MAX_VERTS, yields one
// result with overflow set. New vertices queue while a polygon is being
// clipped.
module polygon_plane_clipper #(
    parameter int MAX_VERTS = 64,
    parameter int MAX_PLANES = 6
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic signed [15:0] vx,
    input  wire logic signed [15:0] vy,
    input  wire logic signed [15:0] vz,
    input  wire logic               final_vertex,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic signed [15:0]      ox,
    output logic signed [15:0]      oy,
    output logic signed [15:0]      oz,
    output logic                    end_of_polygon,
    output logic                    overflow,
    input  wire logic               cfg_we,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [63:0]        cfg_data
);
    import ppc_pkg::*;
    fq_item_t in_item, q_item;
    logic q_valid, q_ready;
    logic [2:0]  plane_count_reg;
    logic [63:0] plane_reg [PLANE_REGS];
    vert_t o_vert;

    // register file: index 0 is the plane count, 1..6 the planes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plane_count_reg <= '0;
            for (int i = 0; i < PLANE_REGS; i++) plane_reg[i] <= '0;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_PLANE_COUNT) plane_count_reg <= cfg_data[2:0];
            else if (cfg_index <= 3'(PLANE_REGS)) plane_reg[cfg_index - 3'd1] <= cfg_data;
        end
    end

    assign in_item.vert.x = vx;
    assign in_item.vert.y = vy;
    assign in_item.vert.z = vz;
    assign in_item.last = final_vertex;

    ppc_front u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .in_item(in_item), .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
    );

    ppc_back #(.MAX_VERTS(MAX_VERTS), .MAX_PLANES(MAX_PLANES)) u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_ready(q_ready),
        .q_item(q_item), .plane_count(plane_count_reg), .planes(plane_reg),
        .o_valid(out_valid), .o_ready(out_ready), .o_vert(o_vert),
        .o_last(end_of_polygon), .o_ovf(overflow)
    );

    assign ox = o_vert.x;
    assign oy = o_vert.y;
    assign oz = o_vert.z;
endmodule
`default_nettype wire

/* dv/ppc_checker.sv */
// checker for the polygon plane clipper: clipping predictor and result compare
`timescale 1ns / 1ps
module ppc_checker
    import ppc_pkg::*;
#(
    parameter int MAX_VERTS = 64,
    parameter int MAX_PLANES = 6
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  wire logic               in_ready,
    input  wire logic signed [15:0] vx,
    input  wire logic signed [15:0] vy,
    input  wire logic signed [15:0] vz,
    input  wire logic               final_vertex,
    input  wire logic               out_valid,
    input  wire logic               out_ready,
    input  wire logic signed [15:0] ox,
    input  wire logic signed [15:0] oy,
    input  wire logic signed [15:0] oz,
    input  wire logic               end_of_polygon,
    input  wire logic               overflow,
    input  wire logic               cfg_we,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [63:0]        cfg_data,
    output int                      fail_count,
    output int                      pending
);
    typedef struct packed {
        vert_t v;
        logic  eop;
        logic  ovf;
    } clip_out_t;

    clip_out_t  expected_verts[$];
    vert_t      poly[$];
    bit         poly_too_big;
    logic [2:0] plane_cnt;
    logic [63:0] planes[PLANE_REGS];

    assign pending = expected_verts.size();

    function automatic longint side_value(logic [63:0] pl, vert_t v);
        longint a, b, c, d;
        a = longint'($signed(pl[15:0]));
        b = longint'($signed(pl[31:16]));
        c = longint'($signed(pl[47:32]));
        d = longint'($signed(pl[63:48]));
        return a * v.x + b * v.y + c * v.z + d * 256;
    endfunction

    // rounded to nearest, ties away from zero
    function automatic logic signed [15:0] lerp_coord(longint q, longint p,
                                                      longint tq, longint tp);
        longint den, num, mag, r;
        den = tp - tq;
        num = -tq * (p - q);
        if (den < 0)
        begin
            den = -den;
            num = -num;
        end
        mag = num < 0 ? -num : num;
        r = (mag + den / 2) / den;
        return 16'(q + (num < 0 ? -r : r));
    endfunction

    task automatic push_error();
        clip_out_t e;
        e = '0;
        e.eop = 1'b1;
        e.ovf = 1'b1;
        expected_verts.push_back(e);
    endtask

    task automatic clip_polygon();
        vert_t src[$];
        vert_t dst[$];
        vert_t q, p, s;
        longint tq, tp;
        int np;
        clip_out_t e;
        src = poly;
        np = plane_cnt > MAX_PLANES ? MAX_PLANES : plane_cnt;
        for (int i = 0; i < np; i++)
        begin
            dst.delete();
            q = src[src.size() - 1];
            tq = side_value(planes[i], q);
            foreach (src[j])
            begin
                p = src[j];
                tp = side_value(planes[i], p);
                if ((tp >= 0) != (tq >= 0))
                begin
                    if (dst.size() >= MAX_VERTS)
                    begin
                        push_error();
                        return;
                    end
                    s.x = lerp_coord(q.x, p.x, tq, tp);
                    s.y = lerp_coord(q.y, p.y, tq, tp);
                    s.z = lerp_coord(q.z, p.z, tq, tp);
                    dst.push_back(s);
                end
                if (tp >= 0)
                begin
                    if (dst.size() >= MAX_VERTS)
                    begin
                        push_error();
                        return;
                    end
                    dst.push_back(p);
                end
                q = p;
                tq = tp;
            end
            if (dst.size() == 0)
                return;
            src = dst;
        end
        foreach (src[j])
        begin
            e.v = src[j];
            e.eop = (j == src.size() - 1);
            e.ovf = 1'b0;
            expected_verts.push_back(e);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        clip_out_t exp_v;
        vert_t     vin;
        if (!rst_n)
        begin
            fail_count <= 0;
            plane_cnt = '0;
            foreach (planes[i])
                planes[i] = '0;
            poly.delete();
            poly_too_big = 0;
            expected_verts.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == REG_PLANE_COUNT)
                    plane_cnt = cfg_data[2:0];
                else if (cfg_index <= PLANE_REGS)
                    planes[cfg_index - 1] = cfg_data;
            end
            if (in_valid && in_ready)
            begin
                vin.x = vx;
                vin.y = vy;
                vin.z = vz;
                if (poly.size() < MAX_VERTS)
                    poly.push_back(vin);
                else
                    poly_too_big = 1;
                if (final_vertex)
                begin
                    if (poly_too_big)
                        push_error();
                    else
                        clip_polygon();
                    poly.delete();
                    poly_too_big = 0;
                end
            end
            if (out_valid && out_ready)
            begin
                if (expected_verts.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("unexpected result %0d %0d %0d eop=%0b ovf=%0b",
                                 ox, oy, oz, end_of_polygon, overflow);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    exp_v = expected_verts.pop_front();
                    if (ox !== exp_v.v.x || oy !== exp_v.v.y || oz !== exp_v.v.z ||
                        end_of_polygon !== exp_v.eop || overflow !== exp_v.ovf)
                    begin
                        if (fail_count < 10)
                            $display("mismatch: exp %0d %0d %0d %0b %0b got %0d %0d %0d %0b %0b",
                                     exp_v.v.x, exp_v.v.y, exp_v.v.z, exp_v.eop, exp_v.ovf,
                                     ox, oy, oz, end_of_polygon, overflow);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

/* dv/testbench.sv */
// top of the polygon plane clipper testbench: stimulus, stalls and verdict
`timescale 1ns / 1ps
module testbench;
    import ppc_pkg::*;

    localparam int WATCHDOG_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 20000;

    logic clk = 0;
    logic rst_n = 0;
    logic in_valid = 0;
    logic in_ready;
    logic signed [15:0] vx = 0, vy = 0, vz = 0;
    logic final_vertex = 0;
    logic out_valid;
    logic out_ready = 0;
    logic signed [15:0] ox, oy, oz;
    logic end_of_polygon, overflow;
    logic cfg_we = 0;
    logic [2:0] cfg_index = 0;
    logic [63:0] cfg_data = 0;
    int fail_count;
    int pending;
    int idle_cycles = 0;
    bit long_hold = 0;
    bit rx_fast = 0;
    bit tx_fast = 0;

    always #5 clk = ~clk;

    polygon_plane_clipper dut (.*);
    ppc_checker chk (.*);

    // sender gap between items
    task automatic send_vertex(logic signed [15:0] x, y, z, logic fin);
        int gap;
        gap = tx_fast ? 0 : $urandom_range(0, 11);
        if (gap > 0)
        begin
            in_valid <= 0;
            repeat (gap) @(posedge clk);
        end
        vx <= x;
        vy <= y;
        vz <= z;
        final_vertex <= fin;
        in_valid <= 1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic send_polygon(int n, int span);
        for (int i = 0; i < n; i++)
            send_vertex($signed(16'($urandom_range(0, 2 * span) - span)),
                        $signed(16'($urandom_range(0, 2 * span) - span)),
                        $signed(16'($urandom_range(0, 2 * span) - span)), i == n - 1);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [63:0] val);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_we <= 1;
        @(posedge clk);
        cfg_we <= 0;
        @(posedge clk);
    endtask

    // wait for every result, then leave time for a polygon that yields nothing
    task automatic drain();
        in_valid <= 0;
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // random plane through a region near the origin, coefficients small
    function automatic logic [63:0] rand_plane();
        logic [15:0] a, b, c, d;
        a = 16'($urandom_range(0, 1024) - 512);
        b = 16'($urandom_range(0, 1024) - 512);
        c = 16'($urandom_range(0, 1024) - 512);
        d = 16'($urandom_range(0, 2048) - 1024);
        return {d, c, b, a};
    endfunction

    task automatic random_planes(int cnt);
        for (int i = 1; i <= PLANE_REGS; i++)
            write_reg(3'(i), rand_plane());
        write_reg(REG_PLANE_COUNT, 3'(cnt));
    endtask

    // receiver: random stalls, one long hold when asked
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            int gap;
            @(posedge clk);
            if (long_hold)
            begin
                out_ready <= 0;
                repeat (600) @(posedge clk);
                long_hold = 0;
            end
            gap = rx_fast ? 0 : $urandom_range(0, 11);
            if (gap > 0)
            begin
                out_ready <= 0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
        end
    end

    // watchdog on cycles with no accepted item on either channel and no configuration write
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("polygon_plane_clipper test failed");
            $finish;
        end
    end

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // no planes: polygon passes unchanged, extremes of the coordinates
        send_vertex(16'sh7fff, 16'sh8000, 16'sh0000, 0);
        send_vertex(16'sh8000, 16'sh7fff, 16'sh7fff, 0);
        send_vertex(16'shffff, 16'sh0001, 16'sh8000, 1);
        send_vertex(16'sh0100, 16'sh0100, 16'sh0100, 1);
        drain();

        // plane x >= 0, plane count above maximum clamps to six
        write_reg(3'd1, {16'sh0000, 16'sh0000, 16'sh0000, 16'sh0100});
        for (int i = 2; i <= PLANE_REGS; i++)
            write_reg(3'(i), 64'h0100_0000_0000_0000);
        write_reg(REG_PLANE_COUNT, 3'd7);
        // crossing triangle
        send_vertex(-16'sd256, 16'sd0, 16'sd0, 0);
        send_vertex(16'sd256, 16'sd100, 16'sd0, 0);
        send_vertex(16'sd256, -16'sd100, 16'sd50, 1);
        // wholly clipped
        send_vertex(-16'sd10, 16'sd5, 16'sd5, 0);
        send_vertex(-16'sd20, 16'sd5, 16'sd5, 1);
        // two vertex polygon crossing at extremes
        send_vertex(16'sh8000, 16'sh7fff, 16'sh8000, 0);
        send_vertex(16'sh7fff, 16'sh8000, 16'sh7fff, 1);
        drain();

        // extreme plane coefficients
        write_reg(3'd1, 64'h8000_7fff_8000_7fff);
        write_reg(REG_PLANE_COUNT, 3'd1);
        send_polygon(4, 32767);
        drain();

        // too many input vertices
        write_reg(REG_PLANE_COUNT, 3'd0);
        tx_fast = 1;
        send_polygon(70, 1000);
        tx_fast = 0;
        drain();

        // clipping overflow: 64 vertices alternating across x >= 0
        write_reg(3'd1, {16'sh0000, 16'sh0000, 16'sh0000, 16'sh0100});
        write_reg(REG_PLANE_COUNT, 3'd1);
        for (int i = 0; i < 64; i++)
            send_vertex((i % 2) ? 16'sd300 : -16'sd300, 16'(i * 10), 16'sd0, i == 63);
        drain();

        // random phases with a fresh plane set each time
        for (int phase = 0; phase < 8; phase++)
        begin
            random_planes(phase == 0 ? 0 : (phase == 1 ? 6 : $urandom_range(0, 7)));
            if (phase == 3)
            begin
                long_hold = 1;
                rx_fast = 0;
            end
            rx_fast = (phase == 5);
            for (int k = 0; k < 4; k++)
            begin
                int n;
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 6);
                if ($urandom_range(0, 3) == 0)
                    send_polygon(n, 32767);
                else
                    send_polygon(n, 2048);
            end
            // sender pause until every result is in
            drain();
        end
        rx_fast = 0;

        if (fail_count == 0)
            $display("polygon_plane_clipper test passed");
        else
            $display("polygon_plane_clipper test failed");
        $finish;
    end
endmodule
